### rtl/complex_kronecker_product_defines.svh
// Assertion macros shared by the RTL of the Kronecker product block.
// Both expect signals clk and rst_n in the scope where they are used.
`ifndef COMPLEX_KRONECKER_PRODUCT_DEFINES_SVH
`define COMPLEX_KRONECKER_PRODUCT_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define CKP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define CKP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ckp_pkg.sv
package ckp_pkg;

  // Field widths
  localparam int IDX_W     = 10;
  localparam int AMP_W     = 16;
  localparam int OUT_IDX_W = 16;
  localparam int CFG_W     = 3;

  // Second-vector store geometry
  localparam int MAX_B_QUBITS = 6;
  localparam int B_DEPTH      = 1 << MAX_B_QUBITS;
  localparam int B_AW         = MAX_B_QUBITS;
  localparam int B_W          = 2 * AMP_W;

  // Packed stream widths
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;

  // Product and accumulator widths (Q2.30 products, Q3.30 sum of two products)
  localparam int PROD_W = 2 * AMP_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam int SHR_W  = ACC_W + 1 - (AMP_W - 1);

  // Q3.30 to Q1.15: round to nearest with ties up, then saturate
  function automatic logic signed [AMP_W-1:0] round_q15(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W:0]   biased;
    logic signed [SHR_W-1:0] shifted;
    biased  = {x[ACC_W-1], x} + (ACC_W+1)'(1 << (AMP_W - 2));
    shifted = biased[ACC_W:AMP_W-1];
    if (shifted > SHR_W'(signed'((1 << (AMP_W - 1)) - 1))) begin
      return {1'b0, {(AMP_W-1){1'b1}}};
    end else if (shifted < -SHR_W'(signed'(1 << (AMP_W - 1)))) begin
      return {1'b1, {(AMP_W-1){1'b0}}};
    end else begin
      return shifted[AMP_W-1:0];
    end
  endfunction

endpackage

### rtl/ckp_ram.sv
// Simple dual-port RAM, one write and one registered read port
module ckp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/complex_kronecker_product.sv
// Store request: accepted whenever the block is idle, no result.
// Multiply request: each result takes a store read, four multiply steps on one
// shared 16x16 multiplier and an output load; the item stays busy for all
// 2^b_qubits results plus any output stall, then the block is ready again.
// Reset (rst_n low, synchronous) clears control state and b_qubits; the store
// holds nothing defined until written.
`include "complex_kronecker_product_defines.svh"

module complex_kronecker_product import ckp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // config: b_qubits
  input  logic                  cfg_we,
  input  logic [CFG_W-1:0]      cfg_wdata,
  // in_tdata: elem_index[9:0], amp_re[25:10], amp_im[41:26], zero pad [47:42]
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser: req_type
  input  logic                  in_tuser,
  // out_tdata: out_index[15:0], prod_re[31:16], prod_im[47:32]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  // out_tlast: row_last
  output logic                  out_tlast
);

  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_MAC, ST_FIN} state_t;

  state_t                  state_r, state_nxt;
  logic [1:0]              step_r, step_nxt;
  logic [B_AW-1:0]         j_r, j_nxt;
  logic [B_AW-1:0]         mask_r, mask_nxt;
  logic [OUT_IDX_W-1:0]    base_r, base_nxt;
  logic signed [AMP_W-1:0] a_re_r, a_re_nxt;
  logic signed [AMP_W-1:0] a_im_r, a_im_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [AMP_W-1:0] re_q_r, re_q_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]   out_data_r, out_data_nxt;
  logic                    out_last_r, out_last_nxt;
  logic [CFG_W-1:0]        bq_r, bq_nxt;

  logic                    in_acc;
  logic [IDX_W-1:0]        in_idx;
  logic signed [AMP_W-1:0] in_re;
  logic signed [AMP_W-1:0] in_im;
  logic                    ram_we;
  logic                    ram_re;
  logic [B_W-1:0]          ram_rdata;
  logic signed [AMP_W-1:0] b_re;
  logic signed [AMP_W-1:0] b_im;
  logic signed [AMP_W-1:0] mul_a;
  logic signed [AMP_W-1:0] mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic                    slot_free;

  // Input unpack
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_idx    = in_tdata[IDX_W-1:0];
  assign in_re     = in_tdata[IDX_W+AMP_W-1:IDX_W];
  assign in_im     = in_tdata[IDX_W+2*AMP_W-1:IDX_W+AMP_W];

  // Second-vector store; out-of-range store indexes are dropped
  assign ram_we = in_acc && !in_tuser && (in_idx[IDX_W-1:B_AW] == '0);
  assign ram_re = (state_r == ST_READ);

  ckp_ram #(
    .WIDTH(B_W),
    .DEPTH(B_DEPTH)
  ) u_b_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(in_idx[B_AW-1:0]),
    .wdata({in_im, in_re}),
    .re   (ram_re),
    .raddr(j_r),
    .rdata(ram_rdata)
  );

  assign b_re = ram_rdata[AMP_W-1:0];
  assign b_im = ram_rdata[B_W-1:AMP_W];

  // Shared multiplier: step 0 re*bre, 1 im*bim, 2 re*bim, 3 im*bre
  assign mul_a = step_r[0] ? a_im_r : a_re_r;
  assign mul_b = (step_r[0] ^ step_r[1]) ? b_im : b_re;
  assign mul_p = mul_a * mul_b;

  assign slot_free = !out_valid_r || out_tready;

  // Sequencer next state
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    j_nxt         = j_r;
    mask_nxt      = mask_r;
    base_nxt      = base_r;
    a_re_nxt      = a_re_r;
    a_im_nxt      = a_im_r;
    acc_nxt       = acc_r;
    re_q_nxt      = re_q_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_tready;
    bq_nxt        = bq_r;

    // b_qubits saturates to the store size
    if (cfg_we) begin
      bq_nxt = (cfg_wdata > CFG_W'(MAX_B_QUBITS)) ? CFG_W'(MAX_B_QUBITS) : cfg_wdata;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_tuser) begin
          a_re_nxt  = in_re;
          a_im_nxt  = in_im;
          base_nxt  = OUT_IDX_W'(in_idx) << bq_r;
          mask_nxt  = ~({B_AW{1'b1}} << bq_r);
          j_nxt     = '0;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        step_nxt  = '0;
        state_nxt = ST_MAC;
      end
      ST_MAC: begin
        unique case (step_r)
          2'd0: acc_nxt = {mul_p[PROD_W-1], mul_p};
          2'd1: acc_nxt = acc_r - {mul_p[PROD_W-1], mul_p};
          2'd2: begin
            re_q_nxt = round_q15(acc_r);
            acc_nxt  = {mul_p[PROD_W-1], mul_p};
          end
          default: acc_nxt = acc_r + {mul_p[PROD_W-1], mul_p};
        endcase
        step_nxt = step_r + 2'd1;
        if (step_r == 2'd3) begin
          state_nxt = ST_FIN;
        end
      end
      default: begin
        // hand the product to the output register once it is free
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {round_q15(acc_r), re_q_r, base_r | OUT_IDX_W'(j_r)};
          out_last_nxt  = (j_r == mask_r);
          if (j_r == mask_r) begin
            state_nxt = ST_IDLE;
          end else begin
            j_nxt     = j_r + 1'b1;
            state_nxt = ST_READ;
          end
        end
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      bq_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      bq_r        <= bq_nxt;
    end
    j_r        <= j_nxt;
    mask_r     <= mask_nxt;
    base_r     <= base_nxt;
    a_re_r     <= a_re_nxt;
    a_im_r     <= a_im_nxt;
    acc_r      <= acc_nxt;
    re_q_r     <= re_q_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // Checks
  `CKP_ASSERT_NEXT(a_mul_start, in_tvalid && in_tready && in_tuser,
    state_r == ST_READ && j_r == '0, "multiply request did not start at first entry")
  `CKP_ASSERT_NEXT(a_mac_done, state_r == ST_MAC && step_r == 2'd3,
    state_r == ST_FIN, "multiply steps did not end in output load")
  `CKP_ASSERT_NEXT(a_fin_load, state_r == ST_FIN && slot_free,
    out_valid_r, "finished product not presented")
  `CKP_ASSERT_NEXT(a_row_end, state_r == ST_FIN && slot_free && j_r == mask_r,
    state_r == ST_IDLE && out_last_r, "row did not close with last mark")

endmodule

### tb/complex_kronecker_product_tb.sv
module complex_kronecker_product_tb;
  import ckp_pkg::*;

  typedef enum logic {
    REQ_STORE = 1'b0,
    REQ_MULT  = 1'b1
  } req_kind_t;

  // one product as it leaves the block
  typedef struct packed {
    logic [OUT_IDX_W-1:0] index;
    logic [AMP_W-1:0]     re;
    logic [AMP_W-1:0]     im;
    logic                 last;
  } product_t;

  // directed stimulus row; cfg is written first unless NO_CFG
  typedef struct {
    int               cfg;
    req_kind_t        kind;
    logic [IDX_W-1:0] idx;
    logic [AMP_W-1:0] re;
    logic [AMP_W-1:0] im;
    bit               typed;
    logic [AMP_W-1:0] exp_re;
    logic [AMP_W-1:0] exp_im;
  } dir_row_t;

  localparam int NO_CFG = -1;
  localparam int SETTLE_CYCLES = 12;
  localparam int CFG_PLAN [12] = '{7, 3, 0, 5, 1, 6, 2, 4, 0, 2, 7, 1};
  localparam int SND_IDLE [3] = '{36, 45, 0};
  localparam int RCV_IDLE [3] = '{45, 36, 0};

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_W-1:0]      cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  // mirror of the block state
  logic [B_W-1:0]   b_mirror [B_DEPTH];
  bit               b_written [B_DEPTH];
  logic [CFG_W-1:0] b_qubits_cfg = '0;

  product_t expected_products [$];
  dir_row_t directed [$];
  int err_count = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;

  complex_kronecker_product dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #1 clk = ~clk;

  // Q3.30 sum to Q1.15: round half up, clamp
  function automatic logic [AMP_W-1:0] to_q15(input longint acc);
    longint r;
    r = (acc + 64'sd16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[AMP_W-1:0];
  endfunction

  function automatic int row_len();
    return 1 << ((b_qubits_cfg > MAX_B_QUBITS) ? MAX_B_QUBITS : int'(b_qubits_cfg));
  endfunction

  function automatic int unwritten_in_row();
    int n;
    n = 0;
    for (int j = 0; j < row_len(); j++) if (!b_written[j]) n++;
    return n;
  endfunction

  function automatic int first_unwritten();
    for (int j = 0; j < B_DEPTH; j++) if (!b_written[j]) return j;
    return 0;
  endfunction

  // one product per stored row entry for a first-vector element
  task automatic predict_row(input logic [IDX_W-1:0] a_idx, input logic signed [AMP_W-1:0] are,
                             input logic signed [AMP_W-1:0] aim);
    int len;
    longint br, bi, pr, pi;
    product_t p;
    len = row_len();
    for (int j = 0; j < len; j++) begin
      br = signed'(b_mirror[j][AMP_W-1:0]);
      bi = signed'(b_mirror[j][B_W-1:AMP_W]);
      pr = longint'(are) * br - longint'(aim) * bi;
      pi = longint'(are) * bi + longint'(aim) * br;
      p.index = OUT_IDX_W'(int'(a_idx) * len + j);
      p.re = to_q15(pr);
      p.im = to_q15(pi);
      p.last = (j == len - 1);
      expected_products.push_back(p);
    end
  endtask

  function automatic logic [AMP_W-1:0] rand_amp();
    logic [7:0] b;
    b = 8'($urandom);
    case ($urandom_range(5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return {{8{b[7]}}, b};
      default: return 16'($urandom);
    endcase
  endfunction

  // send one request, then update the mirror or the expectations on accept
  task automatic send_req(input req_kind_t kind, input logic [IDX_W-1:0] idx,
                          input logic [AMP_W-1:0] re, input logic [AMP_W-1:0] im,
                          input bit typed = 1'b0, input logic [AMP_W-1:0] exp_re = '0,
                          input logic [AMP_W-1:0] exp_im = '0);
    product_t p;
    @(negedge clk);
    while (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {6'b0, im, re, idx};
    do @(posedge clk); while (!in_tready);
    if (kind == REQ_STORE) begin
      if (idx < B_DEPTH) begin
        b_mirror[idx[B_AW-1:0]] = {im, re};
        b_written[idx[B_AW-1:0]] = 1'b1;
      end
    end else if (typed) begin
      p = '{index: OUT_IDX_W'(idx), re: exp_re, im: exp_im, last: 1'b1};
      expected_products.push_back(p);
    end else begin
      predict_row(idx, re, im);
    end
  endtask

  // drop valid, wait for every product, then let the block settle
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_products.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_b_qubits(input int value);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= CFG_W'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    b_qubits_cfg = CFG_W'(value);
  endtask

  task automatic check_field(input string name, input logic [AMP_W-1:0] want,
                             input logic [AMP_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      err_count++;
    end
  endtask

  // receiver backpressure
  always @(negedge clk) out_tready <= ($urandom_range(99) >= rcv_idle_pct);

  // compare each accepted product against the oldest expectation
  always @(posedge clk) begin
    product_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_products.size() == 0) begin
        $display("%0t: unexpected product, expected none, got %h last %b",
                 $time, out_tdata, out_tlast);
        err_count++;
      end else begin
        want = expected_products.pop_front();
        check_field("out_index", want.index, out_tdata[15:0]);
        check_field("prod_re", want.re, out_tdata[31:16]);
        check_field("prod_im", want.im, out_tdata[47:32]);
        check_field("row_last", AMP_W'(want.last), AMP_W'(out_tlast));
      end
    end
  end

  initial begin
    #4000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int len, n, r, thr;
    logic [IDX_W-1:0] idx;
    dir_row_t row;

    for (int j = 0; j < B_DEPTH; j++) begin
      b_mirror[j] = '0;
      b_written[j] = 1'b0;
    end

    // extremes, rounding ties, saturation, ignored stores; row length one
    directed.push_back(dir_row_t'{NO_CFG, REQ_STORE, 10'd0, 16'h7FFF, 16'h0000, 0, 0, 0});
    directed.push_back(dir_row_t'{NO_CFG, REQ_MULT, 10'd0, 16'h7FFF, 16'h0000,
                                  1, 16'h7FFE, 16'h0000});
    directed.push_back(dir_row_t'{NO_CFG, REQ_STORE, 10'd0, 16'h8000, 16'h0000, 0, 0, 0});
    // (-1)*(-1) clamps to max
    directed.push_back(dir_row_t'{NO_CFG, REQ_MULT, 10'd5, 16'h8000, 16'h0000,
                                  1, 16'h7FFF, 16'h0000});
    directed.push_back(dir_row_t'{NO_CFG, REQ_MULT, 10'd1023, 16'h0000, 16'h8000,
                                  1, 16'h0000, 16'h7FFF});
    directed.push_back(dir_row_t'{NO_CFG, REQ_STORE, 10'd0, 16'h8000, 16'h8000, 0, 0, 0});
    directed.push_back(dir_row_t'{NO_CFG, REQ_MULT, 10'd2, 16'h8000, 16'h8000,
                                  1, 16'h0000, 16'h7FFF});
    directed.push_back(dir_row_t'{NO_CFG, REQ_MULT, 10'd3, 16'h7FFF, 16'h7FFF,
                                  1, 16'h0000, 16'h8000});
    // half-LSB ties round toward plus infinity
    directed.push_back(dir_row_t'{NO_CFG, REQ_STORE, 10'd0, 16'h0001, 16'h0000, 0, 0, 0});
    directed.push_back(dir_row_t'{NO_CFG, REQ_MULT, 10'd4, 16'h4000, 16'hC000,
                                  1, 16'h0001, 16'h0000});
    // stores beyond the store depth are dropped
    directed.push_back(dir_row_t'{NO_CFG, REQ_STORE, 10'd64, 16'h1234, 16'h5678, 0, 0, 0});
    directed.push_back(dir_row_t'{NO_CFG, REQ_STORE, 10'd1023, 16'hFFFF, 16'hFFFF, 0, 0, 0});
    directed.push_back(dir_row_t'{NO_CFG, REQ_MULT, 10'd7, 16'h7FFF, 16'h0000,
                                  1, 16'h0001, 16'h0000});
    directed.push_back(dir_row_t'{NO_CFG, REQ_MULT, 10'd0, 16'h0000, 16'h0000,
                                  1, 16'h0000, 16'h0000});
    // longer rows
    directed.push_back(dir_row_t'{1, REQ_STORE, 10'd1, 16'h4000, 16'hC000, 0, 0, 0});
    directed.push_back(dir_row_t'{NO_CFG, REQ_MULT, 10'd1023, 16'h7FFF, 16'h8000, 0, 0, 0});
    directed.push_back(dir_row_t'{2, REQ_STORE, 10'd2, 16'h7FFF, 16'h8000, 0, 0, 0});
    directed.push_back(dir_row_t'{NO_CFG, REQ_STORE, 10'd3, 16'h8000, 16'h7FFF, 0, 0, 0});
    directed.push_back(dir_row_t'{NO_CFG, REQ_MULT, 10'd512, 16'h8000, 16'h8000, 0, 0, 0});
    directed.push_back(dir_row_t'{NO_CFG, REQ_MULT, 10'd1, 16'hC000, 16'h4000, 0, 0, 0});

    snd_idle_pct = SND_IDLE[0];
    rcv_idle_pct = RCV_IDLE[0];
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      row = directed[i];
      if (row.cfg != NO_CFG) write_b_qubits(row.cfg);
      send_req(row.kind, row.idx, row.re, row.im, row.typed, row.exp_re, row.exp_im);
    end

    // random phases: row fill first, then mixed stores and multiplies
    for (int m = 0; m < 3; m++) begin
      for (int ph = 0; ph < 4; ph++) begin
        write_b_qubits(CFG_PLAN[m * 4 + ph]);
        snd_idle_pct = SND_IDLE[m];
        rcv_idle_pct = RCV_IDLE[m];
        len = row_len();
        n = 22 + unwritten_in_row();
        thr = (len >= 32) ? 12 : 45;
        for (int k = 0; k < n; k++) begin
          r = $urandom_range(99);
          if (unwritten_in_row() != 0) begin
            send_req(REQ_STORE, IDX_W'(first_unwritten()), rand_amp(), rand_amp());
          end else if (r < thr) begin
            send_req(REQ_MULT, IDX_W'($urandom_range(1023)), rand_amp(), rand_amp());
          end else if (r < thr + 8) begin
            send_req(REQ_STORE, IDX_W'($urandom_range(1023, B_DEPTH)), rand_amp(), rand_amp());
          end else begin
            idx = (r < thr + 20) ? IDX_W'($urandom_range(B_DEPTH - 1))
                                 : IDX_W'($urandom_range(len - 1));
            send_req(REQ_STORE, idx, rand_amp(), rand_amp());
          end
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
